// ===== hw/rtl/blk2b_pkg.sv =====
package blk2b_pkg;

   localparam int unsigned CfgIdxWidth = 3;

   localparam logic [CfgIdxWidth-1:0] CFG_DIGEST_LENGTH  = 3'd0;
   localparam logic [CfgIdxWidth-1:0] CFG_KEY_LENGTH     = 3'd1;
   localparam logic [CfgIdxWidth-1:0] CFG_SALT_LOW       = 3'd2;
   localparam logic [CfgIdxWidth-1:0] CFG_SALT_HIGH      = 3'd3;
   localparam logic [CfgIdxWidth-1:0] CFG_PERSONAL_LOW   = 3'd4;
   localparam logic [CfgIdxWidth-1:0] CFG_PERSONAL_HIGH  = 3'd5;
   localparam logic [CfgIdxWidth-1:0] CFG_LAST_NODE_FLAG = 3'd6;

   localparam logic [3:0] LAST_ROUND = 4'd11;

   typedef struct packed {
      logic       init;
      logic       latch;
      logic       put_byte;
      logic [2:0] byte_sel;
      logic       add_full;
      logic       pad;
      logic       v_init;
      logic       final_blk;
      logic       g_half;
      logic [3:0] round;
      logic [2:0] g_idx;
      logic       half;
      logic       fold;
      logic       out_load;
      logic [2:0] out_idx;
   } cmd_type;

   typedef struct packed {
      logic       fill_full;
      logic [3:0] out_words;
   } status_type;

   function automatic logic [63:0] iv_word(input logic [2:0] i);
      logic [63:0] r;
      case (i)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         default: r = 64'h5be0cd19137e2179;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] sigma(input logic [3:0] round, input logic [3:0] k);
      logic [63:0] row;
      case (round)
         4'd0, 4'd10: row = 64'hFEDCBA9876543210;
         4'd1, 4'd11: row = 64'h357B20C16DF984AE;
         4'd2:        row = 64'h491763EADF250C8B;
         4'd3:        row = 64'h8F04A562EBCD1397;
         4'd4:        row = 64'hD386CB1EFA427509;
         4'd5:        row = 64'h91EF57D438B0A6C2;
         4'd6:        row = 64'hB8293670A4DEF15C;
         4'd7:        row = 64'hA2684F05931CE7BD;
         4'd8:        row = 64'h5A417D2C803B9EF6;
         4'd9:        row = 64'h0DC3E9BF5167482A;
         default:     row = 64'hFEDCBA9876543210;
      endcase
      return row[{k, 2'b00} +: 4];
   endfunction

endpackage

// ===== hw/rtl/blk2b_ctrl.sv =====
module blk2b_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3:0]            req_count,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output blk2b_pkg::cmd_type    cmd,
   input  blk2b_pkg::status_type status
);
   import blk2b_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ABSORB = 3'd1;
   localparam logic [2:0] S_PAD    = 3'd2;
   localparam logic [2:0] S_VINIT  = 3'd3;
   localparam logic [2:0] S_GHALF  = 3'd4;
   localparam logic [2:0] S_FOLD   = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       busy_ff, busy_in;
   logic [3:0] n_ff, n_in;
   logic       last_ff, last_in;
   logic [3:0] bidx_ff, bidx_in;
   logic       fin_ff, fin_in;
   logic [3:0] round_ff, round_in;
   logic [2:0] g_ff, g_in;
   logic       half_ff, half_in;
   logic [2:0] oidx_ff, oidx_in;
   logic       valid_ff, valid_in;
   logic       acc;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      n_in     = n_ff;
      last_in  = last_ff;
      bidx_in  = bidx_ff;
      fin_in   = fin_ff;
      round_in = round_ff;
      g_in     = g_ff;
      half_in  = half_ff;
      oidx_in  = oidx_ff;
      valid_in = valid_ff;
      cmd          = '0;
      cmd.byte_sel = bidx_ff[2:0];
      cmd.final_blk = fin_ff;
      cmd.round    = round_ff;
      cmd.g_idx    = g_ff;
      cmd.half     = half_ff;
      cmd.out_idx  = oidx_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               cmd.latch = 1'b1;
               cmd.init  = !busy_ff;
               busy_in   = 1'b1;
               n_in      = (req_count > 4'd8) ? 4'd8 : req_count;
               last_in   = req_tlast;
               bidx_in   = '0;
               state_in  = S_ABSORB;
            end
         end
         S_ABSORB: begin
            if (bidx_ff != n_ff) begin
               if (status.fill_full) begin
                  cmd.add_full = 1'b1;
                  fin_in       = 1'b0;
                  state_in     = S_VINIT;
               end else begin
                  cmd.put_byte = 1'b1;
                  bidx_in      = bidx_ff + 4'd1;
               end
            end else if (last_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            cmd.pad  = 1'b1;
            fin_in   = 1'b1;
            state_in = S_VINIT;
         end
         S_VINIT: begin
            cmd.v_init = 1'b1;
            round_in   = '0;
            g_in       = '0;
            half_in    = 1'b0;
            state_in   = S_GHALF;
         end
         S_GHALF: begin
            cmd.g_half = 1'b1;
            half_in    = !half_ff;
            if (half_ff) begin
               g_in = g_ff + 3'd1;
               if (g_ff == 3'd7) begin
                  round_in = round_ff + 4'd1;
                  if (round_ff == LAST_ROUND) begin
                     state_in = S_FOLD;
                  end
               end
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            oidx_in  = '0;
            state_in = fin_ff ? S_OUT : S_ABSORB;
         end
         S_OUT: begin
            if (!valid_ff) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
            end else if (rsp_tready) begin
               valid_in = 1'b0;
               if ({1'b0, oidx_ff} + 4'd1 == status.out_words) begin
                  busy_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  oidx_in = oidx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         fin_ff   <= fin_in;
      end
      n_ff     <= n_in;
      last_ff  <= last_in;
      bidx_ff  <= bidx_in;
      round_ff <= round_in;
      g_ff     <= g_in;
      half_ff  <= half_in;
      oidx_ff  <= oidx_in;
   end

endmodule

// ===== hw/rtl/blk2b_dp.sv =====
module blk2b_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_data,
   input  logic [63:0]           req_word,
   input  blk2b_pkg::cmd_type    cmd,
   output blk2b_pkg::status_type status,
   output logic [63:0]           rsp_word,
   output logic [3:0]            rsp_bytes,
   output logic                  rsp_last
);
   import blk2b_pkg::*;

   logic [6:0]  dlen_ff, klen_ff;
   logic [63:0] salt_lo_ff, salt_hi_ff, pers_lo_ff, pers_hi_ff;
   logic        lnode_ff;
   logic [6:0]  out_len_ff;
   logic [63:0] chain_ff [8];
   logic [63:0] v_ff [16];
   logic [63:0] m_ff [16];
   logic [63:0] cnt_lo_ff, cnt_hi_ff;
   logic [7:0]  fill_ff;
   logic [63:0] word_ff;
   logic [63:0] out_word_ff;
   logic [3:0]  out_bytes_ff;
   logic        out_last_ff;

   logic [6:0]  dl, kl;
   logic [3:0]  ia, ib, ic, id;
   logic [63:0] va, vb, vc, vd, mx, a1, d1, c1, b1, dx, bx;
   logic [64:0] cnt_sum;
   logic [63:0] cnt_add;
   logic [6:0]  rem;
   logic [3:0]  nb;
   logic [63:0] ow;

   assign dl = (dlen_ff == 7'd0) ? 7'd1 : ((dlen_ff > 7'd64) ? 7'd64 : dlen_ff);
   assign kl = (klen_ff > 7'd64) ? 7'd64 : klen_ff;

   assign status.fill_full = fill_ff[7];
   assign status.out_words = 4'((out_len_ff + 7'd7) >> 3);

   assign ia = {2'b00, cmd.g_idx[1:0]};
   assign ib = cmd.g_idx[2] ? {2'b01, cmd.g_idx[1:0] + 2'd1} : {2'b01, cmd.g_idx[1:0]};
   assign ic = cmd.g_idx[2] ? {2'b10, cmd.g_idx[1:0] + 2'd2} : {2'b10, cmd.g_idx[1:0]};
   assign id = cmd.g_idx[2] ? {2'b11, cmd.g_idx[1:0] + 2'd3} : {2'b11, cmd.g_idx[1:0]};
   assign va = v_ff[ia];
   assign vb = v_ff[ib];
   assign vc = v_ff[ic];
   assign vd = v_ff[id];
   assign mx = m_ff[sigma(cmd.round, {cmd.g_idx, cmd.half})];
   assign a1 = va + vb + mx;
   assign dx = vd ^ a1;
   assign d1 = cmd.half ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
   assign c1 = vc + d1;
   assign bx = vb ^ c1;
   assign b1 = cmd.half ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};

   assign cnt_add = cmd.add_full ? 64'd128 : {56'd0, fill_ff};
   assign cnt_sum = {1'b0, cnt_lo_ff} + {1'b0, cnt_add};

   assign rem = out_len_ff - {1'b0, cmd.out_idx, 3'b000};
   assign nb  = (rem > 7'd8) ? 4'd8 : rem[3:0];
   always_comb begin
      ow = chain_ff[cmd.out_idx];
      for (int j = 0; j < 8; j++) begin
         if (4'(j) >= nb) begin
            ow[8*j +: 8] = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dlen_ff    <= 7'd64;
         klen_ff    <= 7'd0;
         salt_lo_ff <= '0;
         salt_hi_ff <= '0;
         pers_lo_ff <= '0;
         pers_hi_ff <= '0;
         lnode_ff   <= 1'b0;
         fill_ff    <= '0;
         cnt_lo_ff  <= '0;
         cnt_hi_ff  <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CFG_DIGEST_LENGTH:  dlen_ff    <= csr_data[6:0];
               CFG_KEY_LENGTH:     klen_ff    <= csr_data[6:0];
               CFG_SALT_LOW:       salt_lo_ff <= csr_data;
               CFG_SALT_HIGH:      salt_hi_ff <= csr_data;
               CFG_PERSONAL_LOW:   pers_lo_ff <= csr_data;
               CFG_PERSONAL_HIGH:  pers_hi_ff <= csr_data;
               CFG_LAST_NODE_FLAG: lnode_ff   <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.init) begin
            fill_ff   <= '0;
            cnt_lo_ff <= '0;
            cnt_hi_ff <= '0;
         end else if (cmd.add_full || cmd.pad) begin
            cnt_lo_ff <= cnt_sum[63:0];
            cnt_hi_ff <= cnt_hi_ff + {63'd0, cnt_sum[64]};
            if (cmd.add_full) begin
               fill_ff <= '0;
            end
         end else if (cmd.put_byte) begin
            fill_ff <= fill_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         word_ff <= req_word;
      end
      if (cmd.init) begin
         out_len_ff <= dl;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= iv_word(3'(i));
         end
         chain_ff[0] <= iv_word(3'd0) ^ {32'd0, 8'h01, 8'h01, 1'b0, kl, 1'b0, dl};
         chain_ff[4] <= iv_word(3'd4) ^ salt_lo_ff;
         chain_ff[5] <= iv_word(3'd5) ^ salt_hi_ff;
         chain_ff[6] <= iv_word(3'd6) ^ pers_lo_ff;
         chain_ff[7] <= iv_word(3'd7) ^ pers_hi_ff;
      end
      if (cmd.put_byte) begin
         m_ff[fill_ff[6:3]][{fill_ff[2:0], 3'b000} +: 8] <= word_ff[{cmd.byte_sel, 3'b000} +: 8];
      end
      if (cmd.pad && !fill_ff[7]) begin
         for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 8; j++) begin
               if (7'(8 * i + j) >= fill_ff[6:0]) begin
                  m_ff[i][8*j +: 8] <= 8'h00;
               end
            end
         end
      end
      if (cmd.v_init) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i]     <= chain_ff[i];
            v_ff[i + 8] <= iv_word(3'(i));
         end
         v_ff[12] <= iv_word(3'd4) ^ cnt_lo_ff;
         v_ff[13] <= iv_word(3'd5) ^ cnt_hi_ff;
         v_ff[14] <= iv_word(3'd6) ^ {64{cmd.final_blk}};
         v_ff[15] <= iv_word(3'd7) ^ {64{cmd.final_blk && lnode_ff}};
      end
      if (cmd.g_half) begin
         v_ff[ia] <= a1;
         v_ff[ib] <= b1;
         v_ff[ic] <= c1;
         v_ff[id] <= d1;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] ^ v_ff[i] ^ v_ff[i + 8];
         end
      end
      if (cmd.out_load) begin
         out_word_ff  <= ow;
         out_bytes_ff <= nb;
         out_last_ff  <= ({1'b0, cmd.out_idx} + 4'd1 == status.out_words);
      end
   end

   assign rsp_word  = out_word_ff;
   assign rsp_bytes = out_bytes_ff;
   assign rsp_last  = out_last_ff;

endmodule

// ===== hw/rtl/blake2b_hash_engine_core.sv =====
// Each input word of n bytes is accepted, then absorbed one byte per cycle, and the
// core returns to idle before it takes the next word. Absorption pauses for each
// 128-byte block compression, done by one G unit doing a half mix per cycle. After
// the last word the message is padded and its final block compressed; each digest
// word is then loaded into the output register and held until the output side takes it.
// Synchronous active-high reset restores default settings and clears FSM state and flags.
module blake2b_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_word [63:0], byte_count [67:64], zeros above
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // digest_word [63:0], digest_bytes [67:64], zeros above
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import blk2b_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [63:0] rsp_word;
   logic [3:0]  rsp_bytes;

   assign csr_ready = 1'b1;

   blk2b_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_count  (req_tdata[67:64]),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   blk2b_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_word  (req_tdata[63:0]),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word),
      .rsp_bytes (rsp_bytes),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, rsp_bytes, rsp_word};

endmodule
